// ===== rtl/adc_frame_ratiometric_scaler_core_assert.svh =====
// Assertion macros used by the checker of the ADC frame scaler.
`ifndef ADC_FRAME_RATIOMETRIC_SCALER_CORE_ASSERT_SVH
`define ADC_FRAME_RATIOMETRIC_SCALER_CORE_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define ARSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define ARSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/arsc_pkg.sv =====
// Shared constants, types and lane tables of the ADC frame scaler.
package arsc_pkg;
   localparam int ADC_BITS   = 12;
   localparam int CNT_W      = ADC_BITS;
   localparam int DEN_W      = ADC_BITS + 1;
   localparam int REF_W      = 22;
   localparam int GAIN_W     = 20;
   localparam int OFFS_W     = 18;
   localparam int K_W        = GAIN_W;
   localparam int CONST_W    = 20;
   localparam int P1_W       = CNT_W + REF_W;
   localparam int N_W        = P1_W + K_W;
   localparam int D_W        = DEN_W + CONST_W;
   localparam int X_W        = N_W + 1;
   localparam int Q_W        = 18;
   localparam int T_W        = Q_W + 2;
   localparam int RES_W      = 16;
   localparam int RES_SMAX   = (1 << (RES_W - 1)) - 1;
   localparam int RES_SMIN   = -(1 << (RES_W - 1));
   localparam int LANES      = 8;
   localparam int IN_FIELDS  = 9;
   localparam int REQ_DATA_W = ((IN_FIELDS * CNT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = LANES * RES_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = REF_W;

   // Lane order equals the order of the result fields.
   localparam int LN_VIN   = 0;
   localparam int LN_CIN   = 1;
   localparam int LN_VAUX  = 2;
   localparam int LN_VCC   = 3;
   localparam int LN_VCORE = 4;
   localparam int LN_CTEMP = 5;
   localparam int LN_PTC1  = 6;
   localparam int LN_PTC2  = 7;

   // Slots of the raw counts in the input item.
   localparam int IN_PTC1  = 0;
   localparam int IN_PTC2  = 1;
   localparam int IN_CIN   = 2;
   localparam int IN_VIN   = 3;
   localparam int IN_VAUX  = 4;
   localparam int IN_VCC   = 5;
   localparam int IN_VCORE = 6;
   localparam int IN_VREF  = 7;
   localparam int IN_CTEMP = 8;

   // Each lane computes round(count * ref_uv * K / (den * C)).
   localparam logic [K_W-1:0] LANE_K [LANES] = '{
      K_W'(73), K_W'(1), K_W'(5), K_W'(5), K_W'(1), K_W'(0), K_W'(5280), K_W'(5280)};
   localparam logic [CONST_W-1:0] LANE_C [LANES] = '{
      CONST_W'(3000), CONST_W'(2000), CONST_W'(2000), CONST_W'(3000),
      CONST_W'(1000), CONST_W'(1000000), CONST_W'(1000000), CONST_W'(1000000)};

   localparam logic [REF_W-1:0]         NOMINAL_REF_UV = REF_W'(2500000);
   localparam logic [DEN_W-1:0]         NOMINAL_DEN    = DEN_W'(2 ** ADC_BITS);
   localparam logic signed [OFFS_W-1:0] PTC_BIAS       = OFFS_W'(-1200);
   localparam int                       NOMINAL_FS_MV  = 2500;

   localparam logic [REF_W-1:0]         VREF_UV_RST = REF_W'(1212000);
   localparam logic [GAIN_W-1:0]        TGAIN_RST   = GAIN_W'(50000);
   localparam logic signed [OFFS_W-1:0] TOFFS_RST   = OFFS_W'(-28500);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VREF_UV = 2'd0,
      CSR_TGAIN   = 2'd1,
      CSR_TOFFS   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [REF_W-1:0]         vref_uv;
      logic [GAIN_W-1:0]        tgain;
      logic signed [OFFS_W-1:0] toffs;
   } cfg_type;

   typedef struct packed {
      logic [LANES-1:0][CNT_W-1:0] cnt;
      logic [CNT_W-1:0]            vref;
   } frame_type;

   typedef struct packed {
      logic [LANES-1:0][X_W-1:0] x;
      logic [LANES-1:0][D_W-1:0] d;
      logic                      fallback;
   } div_req_type;

   typedef struct packed {
      logic [LANES-1:0][Q_W-1:0] q;
      logic [LANES-1:0]          ovf;
      logic                      fallback;
   } div_rsp_type;
endpackage

// ===== rtl/adc_frame_ratiometric_scaler_core.sv =====
// Top level of the ratiometric ADC frame scaler.
//
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  nine raw counts in req_tdata
// rsp      out  rsp_tvalid/rsp_tready  eight scaled values in rsp_tdata, fallback in rsp_tuser
// csr      in   csr_valid/csr_ready    register index and write data
//
// One item is accepted per cycle unless a stall on rsp fills the pipeline.
// The pipeline is three stages of selection, multiplication and rounding offset,
// eighteen divider stages that each resolve one quotient bit, and the output register.
// Reset is synchronous; it empties the pipeline and loads the register defaults.
// Under a stall each stage holds only while its successor is full, so bubbles close up.
module adc_frame_ratiometric_scaler_core import arsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // ptc1_raw, ptc2_raw, cin_raw, vin_raw, vaux_raw, vcc_raw, vcore_raw,
   // vrefint_raw, coretemp_raw, zero padding
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // vin_mv, cin_ma, vaux_mv, vcc_mv, vcore_mv, core_temp_cdeg,
   // ptc1_temp_cdeg, ptc2_temp_cdeg
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // ref_fallback
   output logic                  rsp_tuser
);
   cfg_type                     cfg_ff, cfg_in;
   frame_type                   frame;
   logic                        prep_valid, prep_ready;
   div_req_type                 div_req;
   logic                        div_valid, div_ready;
   div_rsp_type                 div_rsp;
   logic [LANES-1:0][RES_W-1:0] res;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_VREF_UV: cfg_in.vref_uv = csr_data[REF_W-1:0];
            CSR_TGAIN:   cfg_in.tgain   = csr_data[GAIN_W-1:0];
            CSR_TOFFS:   cfg_in.toffs   = csr_data[OFFS_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{vref_uv: VREF_UV_RST, tgain: TGAIN_RST, toffs: TOFFS_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      frame.cnt[LN_VIN]   = req_tdata[IN_VIN*CNT_W +: CNT_W];
      frame.cnt[LN_CIN]   = req_tdata[IN_CIN*CNT_W +: CNT_W];
      frame.cnt[LN_VAUX]  = req_tdata[IN_VAUX*CNT_W +: CNT_W];
      frame.cnt[LN_VCC]   = req_tdata[IN_VCC*CNT_W +: CNT_W];
      frame.cnt[LN_VCORE] = req_tdata[IN_VCORE*CNT_W +: CNT_W];
      frame.cnt[LN_CTEMP] = req_tdata[IN_CTEMP*CNT_W +: CNT_W];
      frame.cnt[LN_PTC1]  = req_tdata[IN_PTC1*CNT_W +: CNT_W];
      frame.cnt[LN_PTC2]  = req_tdata[IN_PTC2*CNT_W +: CNT_W];
      frame.vref          = req_tdata[IN_VREF*CNT_W +: CNT_W];
   end

   arsc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_frame  (frame),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_req   (div_req)
   );

   arsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_req    (div_req),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_rsp   (div_rsp)
   );

   arsc_fmt u_fmt (
      .clock     (clock),
      .reset     (reset),
      .core_offs (cfg_ff.toffs),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_rsp    (div_rsp),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .res       (res),
      .fallback  (rsp_tuser)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = res;
endmodule

// ===== rtl/arsc_prep.sv =====
// Reference selection, scale multiplications and rounding offset, three stages.
module arsc_prep import arsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   output logic        in_ready,
   input  frame_type   in_frame,
   output logic        out_valid,
   input  logic        out_ready,
   output div_req_type out_req
);
   localparam int STAGES = 3;

   logic [STAGES-1:0]             valid_ff;
   logic [STAGES:0]               ready;
   logic                          fb_in;
   logic [REF_W-1:0]              num;
   logic [DEN_W-1:0]              den;
   logic [STAGES-1:0]             fb_ff;
   logic [LANES-1:0][P1_W-1:0]    p1_ff, p1_in;
   logic [LANES-1:0][D_W-1:0]     d1_ff, d1_in, d2_ff, d3_ff;
   logic [LANES-1:0][N_W-1:0]     n2_ff, n2_in;
   logic [LANES-1:0][X_W-1:0]     x3_ff, x3_in;

   always_comb begin
      ready[STAGES] = out_ready;
      for (int s = STAGES - 1; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s + 1];
      end
   end

   always_comb begin
      fb_in = (in_frame.vref == '0);
      num   = fb_in ? NOMINAL_REF_UV : cfg.vref_uv;
      den   = fb_in ? NOMINAL_DEN : DEN_W'(in_frame.vref);
      for (int l = 0; l < LANES; l++) begin
         p1_in[l] = P1_W'(in_frame.cnt[l]) * P1_W'(num);
         d1_in[l] = D_W'(den) * D_W'(LANE_C[l]);
         n2_in[l] = N_W'(p1_ff[l]) * N_W'((l == LN_CTEMP) ? cfg.tgain : LANE_K[l]);
         x3_in[l] = X_W'(n2_ff[l]) + X_W'(d2_ff[l] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         for (int s = 1; s < STAGES; s++) begin
            if (ready[s]) valid_ff[s] <= valid_ff[s - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         p1_ff    <= p1_in;
         d1_ff    <= d1_in;
         fb_ff[0] <= fb_in;
      end
      if (ready[1]) begin
         n2_ff    <= n2_in;
         d2_ff    <= d1_ff;
         fb_ff[1] <= fb_ff[0];
      end
      if (ready[2]) begin
         x3_ff    <= x3_in;
         d3_ff    <= d2_ff;
         fb_ff[2] <= fb_ff[1];
      end
   end

   always_comb begin
      in_ready         = ready[0];
      out_valid        = valid_ff[STAGES-1];
      out_req.x        = x3_ff;
      out_req.d        = d3_ff;
      out_req.fallback = fb_ff[STAGES-1];
   end
endmodule

// ===== rtl/arsc_div.sv =====
// Eight-lane restoring divider, one quotient bit per pipeline stage.
module arsc_div import arsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  div_req_type in_req,
   output logic        out_valid,
   input  logic        out_ready,
   output div_rsp_type out_rsp
);
   logic [Q_W-1:0]                       valid_ff;
   logic [Q_W:0]                         ready;
   logic [Q_W-1:0][LANES-1:0][X_W-1:0]   rem_cur, rem_in, rem_ff;
   logic [Q_W-1:0][LANES-1:0][D_W-1:0]   d_cur, d_ff;
   logic [Q_W-1:0][LANES-1:0][Q_W-1:0]   q_cur, q_in, q_ff;
   logic [Q_W-1:0][LANES-1:0]            ovf_cur, ovf_in, ovf_ff;
   logic [Q_W-1:0]                       fb_cur, fb_ff;

   always_comb begin
      ready[Q_W] = out_ready;
      for (int k = Q_W - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k + 1];
      end
   end

   always_comb begin
      rem_cur[0] = in_req.x;
      d_cur[0]   = in_req.d;
      q_cur[0]   = '0;
      ovf_cur[0] = '0;
      fb_cur[0]  = in_req.fallback;
      for (int k = 1; k < Q_W; k++) begin
         rem_cur[k] = rem_ff[k - 1];
         d_cur[k]   = d_ff[k - 1];
         q_cur[k]   = q_ff[k - 1];
         ovf_cur[k] = ovf_ff[k - 1];
         fb_cur[k]  = fb_ff[k - 1];
      end
   end

   always_comb begin
      logic [X_W-1:0] trial;
      logic           take;
      for (int k = 0; k < Q_W; k++) begin
         for (int l = 0; l < LANES; l++) begin
            trial         = X_W'(d_cur[k][l]) << (Q_W - 1 - k);
            take          = (rem_cur[k][l] >= trial);
            rem_in[k][l]  = take ? (rem_cur[k][l] - trial) : rem_cur[k][l];
            q_in[k][l]    = q_cur[k][l] | (Q_W'(take) << (Q_W - 1 - k));
            ovf_in[k][l]  = ovf_cur[k][l];
            if (k == 0) begin
               // A quotient that needs more than Q_W bits only has to saturate.
               ovf_in[k][l] = (rem_cur[k][l] >= (X_W'(d_cur[k][l]) << Q_W));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         for (int k = 1; k < Q_W; k++) begin
            if (ready[k]) valid_ff[k] <= valid_ff[k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Q_W; k++) begin
         if (ready[k]) begin
            rem_ff[k] <= rem_in[k];
            d_ff[k]   <= d_cur[k];
            q_ff[k]   <= q_in[k];
            ovf_ff[k] <= ovf_in[k];
            fb_ff[k]  <= fb_cur[k];
         end
      end
   end

   always_comb begin
      in_ready         = ready[0];
      out_valid        = valid_ff[Q_W-1];
      out_rsp.q        = q_ff[Q_W-1];
      out_rsp.ovf      = ovf_ff[Q_W-1];
      out_rsp.fallback = fb_ff[Q_W-1];
   end
endmodule

// ===== rtl/arsc_fmt.sv =====
// Offset, saturation and output register of the scaled results.
module arsc_fmt import arsc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic signed [OFFS_W-1:0]    core_offs,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  div_rsp_type                 in_rsp,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [LANES-1:0][RES_W-1:0] res,
   output logic                        fallback
);
   logic                        valid_ff;
   logic                        fb_ff;
   logic [LANES-1:0][RES_W-1:0] res_ff, res_in;

   always_comb begin
      logic [Q_W-1:0]           qs;
      logic signed [OFFS_W-1:0] offs;
      logic signed [T_W-1:0]    t;
      for (int l = 0; l < LANES; l++) begin
         qs   = in_rsp.ovf[l] ? '1 : in_rsp.q[l];
         offs = (l == LN_CTEMP) ? core_offs : PTC_BIAS;
         t    = $signed({2'b00, qs}) + T_W'(offs);
         if (l < LN_CTEMP) begin
            res_in[l] = (in_rsp.ovf[l] || (in_rsp.q[l][Q_W-1:RES_W] != '0)) ?
                        '1 : in_rsp.q[l][RES_W-1:0];
         end else if (t > RES_SMAX) begin
            res_in[l] = RES_W'(RES_SMAX);
         end else if (t < RES_SMIN) begin
            res_in[l] = RES_W'(RES_SMIN);
         end else begin
            res_in[l] = t[RES_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         res_ff <= res_in;
         fb_ff  <= in_rsp.fallback;
      end
   end

   always_comb begin
      in_ready  = !valid_ff || rsp_ready;
      rsp_valid = valid_ff;
      res       = res_ff;
      fallback  = fb_ff;
   end
endmodule

// ===== rtl/arsc_chk.sv =====
// Port-level checker of the ADC frame scaler and its bind.
`include "adc_frame_ratiometric_scaler_core_assert.svh"
module arsc_chk import arsc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);
   // A held result keeps its payload.
   `ARSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp item changed while stalled")
   // The pipeline leaves reset empty.
   `ARSC_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_tvalid, "rsp_tvalid right after reset")
   // The input only stalls when every stage is full and the output is held.
   `ARSC_ASSERT_NOW(a_stall_source, clock, reset, !req_tready, rsp_tvalid && !rsp_tready, "input stalled without an output stall")
   // With the nominal reference a full-scale core count stays below 2.5 V.
   `ARSC_ASSERT_NOW(a_fallback_range, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[LN_VCORE*RES_W +: RES_W] <= NOMINAL_FS_MV, "core rail beyond nominal full scale")
endmodule

bind adc_frame_ratiometric_scaler_core arsc_chk u_arsc_chk (.*);
